@@ rtl/core/bpu_pkg.sv @@
// ----------------------------------------------------------------------------
// bpu_pkg: shared types and constants of the bitfield pixel unpacker
// Register indexes, field widths and the per-channel decode settings.
// ----------------------------------------------------------------------------
package bpu_pkg;

   localparam int WORD_WIDTH      = 32;
   localparam int CHAN_WIDTH      = 8;
   localparam int SHIFT_WIDTH     = 5;
   localparam int BPP_WIDTH       = 3;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int NUM_CHANNELS    = 3;

   // Channel slots in the settings array
   localparam int CHAN_RED   = 0;
   localparam int CHAN_GREEN = 1;
   localparam int CHAN_BLUE  = 2;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MASK_RED        = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MASK_GREEN      = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MASK_BLUE       = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTES_PER_PIXEL = 2'd3;

   // Reset values of the registers
   localparam logic [WORD_WIDTH-1:0] RESET_MASK_RED   = 32'h00FF_0000;
   localparam logic [WORD_WIDTH-1:0] RESET_MASK_GREEN = 32'h0000_FF00;
   localparam logic [WORD_WIDTH-1:0] RESET_MASK_BLUE  = 32'h0000_00FF;
   localparam logic [BPP_WIDTH-1:0]  RESET_BPP        = 3'd3;

   // Decode settings of one channel, derived from the registers
   typedef struct packed {
      logic [WORD_WIDTH-1:0]  sel_mask;  // channel mask limited to the kept bytes
      logic [SHIFT_WIDTH-1:0] shift;     // trailing-zero count of the mask
      logic [CHAN_WIDTH-1:0]  scale;     // floor(255 / shifted mask), 0 when too wide
   } chan_cfg_type;

   // Trailing-zero count; a zero word counts as zero
   function automatic logic [SHIFT_WIDTH-1:0] trailing_zeros(input logic [WORD_WIDTH-1:0] m);
      logic [SHIFT_WIDTH-1:0] n;
      n = '0;
      for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
         if (m[i]) begin
            n = SHIFT_WIDTH'(i);
         end
      end
      return n;
   endfunction

   // Bytes of the pixel word that stay valid
   function automatic logic [WORD_WIDTH-1:0] keep_mask(input logic [BPP_WIDTH-1:0] bpp);
      logic [WORD_WIDTH-1:0] k;
      case (bpp)
         3'd0:    k = 32'h0000_0000;
         3'd1:    k = 32'h0000_00FF;
         3'd2:    k = 32'h0000_FFFF;
         3'd3:    k = 32'h00FF_FFFF;
         default: k = 32'hFFFF_FFFF;
      endcase
      return k;
   endfunction

endpackage

@@ rtl/core/bpu_cfg.sv @@
// ----------------------------------------------------------------------------
// bpu_cfg: configuration registers and derived channel settings
// Holds the masks and byte count, and registers the shift, scale, kept mask
// and mask error that the datapath uses.
// ----------------------------------------------------------------------------
module bpu_cfg
   import bpu_pkg::*;
(
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]              csr_index,
   input  logic [WORD_WIDTH-1:0]                   csr_data,
   output chan_cfg_type [NUM_CHANNELS-1:0]         chan_cfg,
   output logic                                    mask_error
);

   logic [WORD_WIDTH-1:0] mask_ff [NUM_CHANNELS];
   logic [BPP_WIDTH-1:0]  bpp_ff;

   logic [WORD_WIDTH-1:0]  sel_mask_ff [NUM_CHANNELS];
   logic [SHIFT_WIDTH-1:0] shift_ff    [NUM_CHANNELS];
   logic [WORD_WIDTH-1:0]  norm_ff     [NUM_CHANNELS];
   logic [CHAN_WIDTH-1:0]  scale_ff    [NUM_CHANNELS];
   logic                   error_ff;
   logic                   error_in;

   logic [CHAN_WIDTH-1:0] recip_table [2**CHAN_WIDTH];

   // Quotient table of 255 by every byte value; zero maps to zero
   assign recip_table[0] = '0;
   for (genvar g = 1; g < 2**CHAN_WIDTH; g++) begin : g_recip
      localparam int Divisor = g;
      localparam logic [CHAN_WIDTH-1:0] Quot = CHAN_WIDTH'(255 / Divisor);
      assign recip_table[g] = Quot;
   end

   // Write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff[CHAN_RED]   <= RESET_MASK_RED;
         mask_ff[CHAN_GREEN] <= RESET_MASK_GREEN;
         mask_ff[CHAN_BLUE]  <= RESET_MASK_BLUE;
         bpp_ff              <= RESET_BPP;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MASK_RED:        mask_ff[CHAN_RED]   <= csr_data;
            CSR_MASK_GREEN:      mask_ff[CHAN_GREEN] <= csr_data;
            CSR_MASK_BLUE:       mask_ff[CHAN_BLUE]  <= csr_data;
            CSR_BYTES_PER_PIXEL: bpp_ff              <= csr_data[BPP_WIDTH-1:0];
            default:             bpp_ff              <= bpp_ff;
         endcase
      end
   end

   // Derive shift, kept mask and normalized mask, then the scale from the latter
   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
      logic [SHIFT_WIDTH-1:0] shift_in;
      logic                   wide;

      assign shift_in = trailing_zeros(mask_ff[c]);
      assign wide     = |norm_ff[c][WORD_WIDTH-1:CHAN_WIDTH];

      always_ff @(posedge clock) begin
         sel_mask_ff[c] <= mask_ff[c] & keep_mask(bpp_ff);
         shift_ff[c]    <= shift_in;
         norm_ff[c]     <= mask_ff[c] >> shift_in;
         scale_ff[c]    <= wide ? '0 : recip_table[norm_ff[c][CHAN_WIDTH-1:0]];
      end

      assign chan_cfg[c].sel_mask = sel_mask_ff[c];
      assign chan_cfg[c].shift    = shift_ff[c];
      assign chan_cfg[c].scale    = scale_ff[c];
   end

   // Flag a zero mask, a triple overlap or a union that is not one run of ones
   always_comb begin
      logic [WORD_WIDTH-1:0] uni;
      logic [WORD_WIDTH-1:0] filled;
      logic [WORD_WIDTH:0]   ext;
      uni      = mask_ff[CHAN_RED] | mask_ff[CHAN_GREEN] | mask_ff[CHAN_BLUE];
      filled   = uni | (uni - WORD_WIDTH'(1));
      ext      = {1'b0, filled};
      error_in = (mask_ff[CHAN_RED] == '0) || (mask_ff[CHAN_GREEN] == '0)
              || (mask_ff[CHAN_BLUE] == '0)
              || ((mask_ff[CHAN_RED] & mask_ff[CHAN_GREEN] & mask_ff[CHAN_BLUE]) != '0)
              || ((ext & (ext + (WORD_WIDTH+1)'(1))) != '0);
   end

   always_ff @(posedge clock) begin
      error_ff <= error_in;
   end

   assign mask_error = error_ff;

endmodule

@@ rtl/core/bpu_chan.sv @@
// ----------------------------------------------------------------------------
// bpu_chan: decode datapath of one color channel
// Extracts the field from the pixel word, then scales it to eight bits.
// ----------------------------------------------------------------------------
module bpu_chan
   import bpu_pkg::*;
(
   input  logic                  clock,
   input  logic [WORD_WIDTH-1:0] pixel_word,
   input  chan_cfg_type          cfg,
   input  logic                  mask_error,
   output logic [CHAN_WIDTH-1:0] value
);

   logic [CHAN_WIDTH-1:0]   field_ff;
   logic [CHAN_WIDTH-1:0]   field_in;
   logic [CHAN_WIDTH-1:0]   value_ff;
   logic [CHAN_WIDTH-1:0]   value_in;
   logic [WORD_WIDTH-1:0]   shifted;
   logic [2*CHAN_WIDTH-1:0] product;

   // Mask and align the field, keep its low byte
   assign shifted  = (pixel_word & cfg.sel_mask) >> cfg.shift;
   assign field_in = shifted[CHAN_WIDTH-1:0];

   // Scale the field, drop it on a bad mask set
   assign product  = field_ff * cfg.scale;
   assign value_in = mask_error ? '0 : product[CHAN_WIDTH-1:0];

   always_ff @(posedge clock) begin
      field_ff <= field_in;
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ rtl/core/bitfield_pixel_unpacker.sv @@
// ----------------------------------------------------------------------------
// bitfield_pixel_unpacker: bitfield pixel to 8-bit RGB decoder
// Masks, aligns and scales the red, green and blue fields of a pixel word.
// ----------------------------------------------------------------------------
// An item is taken at every clock edge with start high; busy stays low, so a
// new pixel can enter each cycle. Each item gives one result, shown for one
// cycle with rsp_valid; the three stages are the input register, the field
// extract register and the scale multiply register. The
// receiver cannot stall, so results must be taken as they appear. Write the
// registers only while no item is in flight; a pixel may start on the cycle
// right after the last write.
module bitfield_pixel_unpacker
   import bpu_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [WORD_WIDTH-1:0]      req_pixel_word,
   output logic                       rsp_valid,
   output logic [CHAN_WIDTH-1:0]      rsp_red,
   output logic [CHAN_WIDTH-1:0]      rsp_green,
   output logic [CHAN_WIDTH-1:0]      rsp_blue,
   output logic                       rsp_mask_error,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]      csr_data
);

   chan_cfg_type [NUM_CHANNELS-1:0] chan_cfg;
   logic                            mask_error;
   logic [CHAN_WIDTH-1:0]           chan_value [NUM_CHANNELS];

   logic [WORD_WIDTH-1:0] pixel_ff;
   logic                  in_valid_ff;
   logic                  field_valid_ff;
   logic                  rsp_valid_ff;
   logic                  error_ff;

   assign busy = 1'b0;

   bpu_cfg u_cfg (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .chan_cfg   (chan_cfg),
      .mask_error (mask_error)
   );

   // Capture the pixel word
   always_ff @(posedge clock) begin
      pixel_ff <= req_pixel_word;
      error_ff <= mask_error;
   end

   // Advance the valid bits with each item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         field_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= start & ~busy;
         field_valid_ff <= in_valid_ff;
         rsp_valid_ff   <= field_valid_ff;
      end
   end

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
      bpu_chan u_chan (
         .clock      (clock),
         .pixel_word (pixel_ff),
         .cfg        (chan_cfg[c]),
         .mask_error (mask_error),
         .value      (chan_value[c])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = chan_value[CHAN_RED];
   assign rsp_green      = chan_value[CHAN_GREEN];
   assign rsp_blue       = chan_value[CHAN_BLUE];
   assign rsp_mask_error = error_ff;

endmodule
